// ----- rtl/dfpf_pkg.sv -----
package dfpf_pkg;

  localparam int VALUE_W    = 32;
  localparam int FRAC_W     = 3;
  localparam int TOTAL_W    = 5;
  localparam int CHAR_W     = 8;
  // decimal digits needed for any 32-bit magnitude
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_IW   = $clog2(NUM_DIGITS);
  localparam int SHIFT_CW   = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;

  localparam logic OP_FREE  = 1'b0;
  localparam logic OP_FIXED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/dfpf_if.sv -----
interface dfpf_in_if import dfpf_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               op;
  logic               is_signed;
  logic [VALUE_W-1:0] value;
  logic [FRAC_W-1:0]  frac_digits;
  logic [TOTAL_W-1:0] total_digits;

  modport source (output valid, op, is_signed, value, frac_digits, total_digits,
                  input ready);
  modport sink   (input valid, op, is_signed, value, frac_digits, total_digits,
                  output ready);
endinterface

interface dfpf_out_if import dfpf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

interface dfpf_cfg_if import dfpf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] fill_char;

  modport source (output valid, fill_char, input ready);
  modport sink   (input valid, fill_char, output ready);
endinterface

// ----- rtl/dfpf_cell.sv -----
module dfpf_cell (
  input  logic       clk,
  input  logic       clr,
  input  logic       shift,
  input  logic       cin,
  output logic       cout,
  output logic [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] adj;

  // add-3 correction before the doubling shift
  assign adj   = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign cout  = adj[3];
  assign digit = digit_r;

  always_ff @(posedge clk) begin
    if (clr) begin
      digit_r <= '0;
    end else if (shift) begin
      digit_r <= {adj[2:0], cin};
    end
  end

endmodule

// ----- rtl/decimal_fixed_point_formatter_unit.sv -----
// Decimal fixed-point formatter: turns a 32-bit number into ASCII text.
// in_ch: one beat carries op, is_signed, value, frac_digits, total_digits.
// out_ch: one beat per character, last marks the final character.
// cfg_ch: writes fill_char (reset '0'); always ready, write only while idle.
// The magnitude is converted to decimal by a row of BCD digit cells, one
// bit entering the row per cycle. A prep step then works out the field
// lengths, and characters leave one per cycle while the receiver is ready.
// A new input beat is taken only once the previous item has sent its last
// character into the output register. Fixed mode, unsigned, no integer
// positions and no fraction produces no characters at all.
// A stalled receiver holds the output register; the block waits with it.
// Reset (synchronous, rst_n low) returns to idle, drops any pending beat
// and restores fill_char to '0'.
module decimal_fixed_point_formatter_unit import dfpf_pkg::*; #(
  parameter int MAX_INT_DIGITS  = 15,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic     clk,
  input  logic     rst_n,
  dfpf_in_if.sink  in_ch,
  dfpf_out_if.source out_ch,
  dfpf_cfg_if.sink cfg_ch
);

  localparam int NW = $clog2(MAX_INT_DIGITS + 1);
  localparam int LW = $clog2(MAX_INT_DIGITS + MAX_FRAC_DIGITS + 3);
  localparam int CW = $clog2(NUM_DIGITS + 1);

  state_t state_r, state_nxt;

  logic [CHAR_W-1:0]   fill_r;
  logic                op_r, sgn_r, neg_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic [SHIFT_CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]       n_r;
  logic [CW-1:0]       ncnt_r;
  logic [LW-1:0]       len_r, k_r, k_nxt;
  logic [CHAR_W-1:0]   fc_r;
  logic                has_sign_r;

  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_acc;
  logic                cells_clr, cells_shift;
  logic [NUM_DIGITS:0] carry;
  logic [3:0]          dig [NUM_DIGITS];

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  // ---- digit cell row ----
  assign carry[0]    = mag_r[VALUE_W-1];
  assign cells_clr   = in_acc;
  assign cells_shift = (state_r == ST_CONV);

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    dfpf_cell u_cell (
      .clk   (clk),
      .clr   (cells_clr),
      .shift (cells_shift),
      .cin   (carry[g]),
      .cout  (carry[g+1]),
      .digit (dig[g])
    );
  end

  // ---- input capture ----
  logic                in_neg;
  logic [FRAC_W-1:0]   in_frac;

  assign in_neg  = in_ch.is_signed && in_ch.value[VALUE_W-1];
  assign in_frac = (in_ch.frac_digits > FRAC_W'(MAX_FRAC_DIGITS)) ?
                   FRAC_W'(MAX_FRAC_DIGITS) : in_ch.frac_digits;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_ch.op;
      sgn_r   <= in_ch.is_signed;
      neg_r   <= in_neg;
      frac_r  <= in_frac;
      total_r <= in_ch.total_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= CH_ZERO;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      fill_r <= cfg_ch.fill_char;
    end
  end

  // ---- length setup, from the finished digits ----
  logic [CW-1:0]      sig;
  logic [CW-1:0]      ncnt;
  logic [TOTAL_W:0]   fix_n_raw;
  logic [NW-1:0]      n_val;
  logic [LW-1:0]      len_val;
  logic               has_sign;

  always_comb begin
    sig = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (dig[i] != 4'd0) sig = CW'(i + 1);
    end
    ncnt = (sig > CW'(frac_r)) ? sig - CW'(frac_r) : CW'(1);

    fix_n_raw = (total_r >= TOTAL_W'(frac_r)) ?
                {1'b0, total_r - TOTAL_W'(frac_r)} : '0;
    if (op_r == OP_FREE) begin
      n_val = NW'(ncnt);
    end else if (fix_n_raw > (TOTAL_W+1)'(MAX_INT_DIGITS)) begin
      n_val = NW'(MAX_INT_DIGITS);
    end else begin
      n_val = NW'(fix_n_raw);
    end

    has_sign = neg_r || (op_r == OP_FIXED && sgn_r);
    len_val  = LW'(has_sign) + LW'(n_val) +
               ((frac_r != '0) ? LW'(frac_r) + LW'(1) : LW'(0));
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      n_r        <= n_val;
      ncnt_r     <= ncnt;
      len_r      <= len_val;
      has_sign_r <= has_sign;
      fc_r       <= (!sgn_r && frac_r == '0) ? fill_r : CH_ZERO;
    end
  end

  // ---- character select for position k ----
  logic [LW-1:0]     j, p, idx, f;
  logic [3:0]        d_int, d_frac;
  logic [CHAR_W-1:0] ch;

  always_comb begin
    j   = k_r - LW'(has_sign_r);
    p   = LW'(n_r) - LW'(1) - j;
    idx = LW'(frac_r) + p;
    f   = LW'(frac_r) + LW'(n_r) - j;
    d_int  = (idx < LW'(NUM_DIGITS)) ? dig[idx[DIGIT_IW-1:0]] : 4'd0;
    d_frac = dig[f[DIGIT_IW-1:0]];
    if (has_sign_r && k_r == '0) begin
      ch = neg_r ? CH_MINUS : CH_SPACE;
    end else if (j < LW'(n_r)) begin
      if (p != '0 && p >= LW'(ncnt_r)) begin
        ch = fc_r;
      end else begin
        ch = CH_ZERO + CHAR_W'(d_int);
      end
    end else if (j == LW'(n_r)) begin
      ch = CH_POINT;
    end else begin
      ch = CH_ZERO + CHAR_W'(d_frac);
    end
  end

  // ---- sequencer ----
  logic slot_free;
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mag_nxt   = in_neg ? ~in_ch.value + VALUE_W'(1) : in_ch.value;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt = {mag_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + SHIFT_CW'(1);
        if (cnt_r == SHIFT_CW'(VALUE_W - 1)) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        k_nxt     = '0;
        state_nxt = (len_val == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ch;
          out_last_nxt  = (k_r == len_r - LW'(1));
          k_nxt         = k_r + LW'(1);
          if (k_r == len_r - LW'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
